[rtl/tcmrd_pkg.sv]
`default_nettype none

package tcmrd_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned ITCM_OFF_W = 15;
    localparam int unsigned DTCM_OFF_W = 14;
    localparam int unsigned MAIN_OFF_W = 22;
    localparam int unsigned BOOT_OFF_W = 15;

    localparam logic [7:0]  REGION_MAIN    = 8'h02;
    localparam logic [7:0]  REGION_SHARED  = 8'h03;
    localparam logic [7:0]  REGION_IO      = 8'h04;
    localparam logic [7:0]  REGION_PALETTE = 8'h05;
    localparam logic [7:0]  REGION_VRAM    = 8'h06;
    localparam logic [7:0]  REGION_OAM     = 8'h07;
    localparam logic [7:0]  REGION_BOOT    = 8'hFF;
    localparam logic [15:0] BOOT_PAGE      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITCM_BASE     = 3'd0,
        CFG_ITCM_HIGH     = 3'd1,
        CFG_ITCM_ACCESS   = 3'd2,
        CFG_DTCM_BASE     = 3'd3,
        CFG_DTCM_HIGH     = 3'd4,
        CFG_DTCM_ACCESS   = 3'd5,
        CFG_SHARED_MASK   = 3'd6,
        CFG_SHARED_MAPPED = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_WIDE = 2'd3
    } size_t;

    typedef enum logic [1:0] {
        BUS_CODE   = 2'd0,
        BUS_DATA   = 2'd1,
        BUS_SYSTEM = 2'd2,
        BUS_OTHER  = 2'd3
    } bus_t;

    typedef enum logic [3:0] {
        TGT_UNMAPPED = 4'd0,
        TGT_ITCM     = 4'd1,
        TGT_DTCM     = 4'd2,
        TGT_MAIN     = 4'd3,
        TGT_SHARED   = 4'd4,
        TGT_IO       = 4'd5,
        TGT_PALETTE  = 4'd6,
        TGT_VRAM_BG0 = 4'd7,
        TGT_VRAM_BG1 = 4'd8,
        TGT_VRAM_OB0 = 4'd9,
        TGT_VRAM_OB1 = 4'd10,
        TGT_LCDC     = 4'd11,
        TGT_OAM      = 4'd12,
        TGT_BOOT     = 4'd13,
        TGT_DROP     = 4'd14
    } tgt_t;

    typedef struct packed {
        logic [ADDR_W-1:0] itcm_base;
        logic [ADDR_W-1:0] itcm_high;
        logic [1:0]        itcm_access;
        logic [ADDR_W-1:0] dtcm_base;
        logic [ADDR_W-1:0] dtcm_high;
        logic [1:0]        dtcm_access;
        logic [ADDR_W-1:0] shared_mask;
        logic              shared_mapped;
    } cfg_t;

    // aligned access leaving the first stage
    typedef struct packed {
        logic              valid;
        logic              wr;
        logic              is_byte;
        bus_t              bus;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] fwd;
    } s1_t;

    // window and region decode leaving the second stage
    typedef struct packed {
        logic                  valid;
        logic                  itcm_hit;
        logic                  dtcm_hit;
        logic [ITCM_OFF_W-1:0] itcm_off;
        logic [DTCM_OFF_W-1:0] dtcm_off;
        tgt_t                  region_tgt;
        logic [ADDR_W-1:0]     region_off;
        logic [DATA_W-1:0]     fwd;
    } s2_t;

endpackage

`default_nettype wire

[rtl/tcmrd_cfg.sv]
`default_nettype none

module tcmrd_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tcmrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcmrd_pkg::DATA_W-1:0]    cfg_data,
    output tcmrd_pkg::cfg_t                      cfg
);

    tcmrd_pkg::cfg_t cfg_reg;
    tcmrd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (tcmrd_pkg::cfg_idx_t'(cfg_index))
                tcmrd_pkg::CFG_ITCM_BASE:     cfg_next.itcm_base     = cfg_data;
                tcmrd_pkg::CFG_ITCM_HIGH:     cfg_next.itcm_high     = cfg_data;
                tcmrd_pkg::CFG_ITCM_ACCESS:   cfg_next.itcm_access   = cfg_data[1:0];
                tcmrd_pkg::CFG_DTCM_BASE:     cfg_next.dtcm_base     = cfg_data;
                tcmrd_pkg::CFG_DTCM_HIGH:     cfg_next.dtcm_high     = cfg_data;
                tcmrd_pkg::CFG_DTCM_ACCESS:   cfg_next.dtcm_access   = cfg_data[1:0];
                tcmrd_pkg::CFG_SHARED_MASK:   cfg_next.shared_mask   = cfg_data;
                tcmrd_pkg::CFG_SHARED_MAPPED: cfg_next.shared_mapped = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/tcmrd_align.sv]
`default_nettype none

module tcmrd_align (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         mode,
    input  wire logic [tcmrd_pkg::ADDR_W-1:0] access_addr,
    input  wire logic [1:0]                   access_size,
    input  wire logic [1:0]                   bus_kind,
    input  wire logic [tcmrd_pkg::DATA_W-1:0] write_data,
    output tcmrd_pkg::s1_t                    s1
);

    tcmrd_pkg::s1_t s1_reg;
    tcmrd_pkg::s1_t s1_next;

    always_comb
    begin
        s1_next.valid   = in_valid;
        s1_next.wr      = mode;
        s1_next.bus     = tcmrd_pkg::bus_t'(bus_kind);
        s1_next.is_byte = 1'b0;
        unique case (tcmrd_pkg::size_t'(access_size))
            tcmrd_pkg::SIZE_BYTE:
            begin
                s1_next.is_byte = 1'b1;
                s1_next.addr    = access_addr;
                s1_next.fwd     = {24'd0, write_data[7:0]};
            end
            tcmrd_pkg::SIZE_HALF:
            begin
                s1_next.addr = {access_addr[tcmrd_pkg::ADDR_W-1:1], 1'b0};
                s1_next.fwd  = {16'd0, write_data[15:0]};
            end
            default:
            begin
                s1_next.addr = {access_addr[tcmrd_pkg::ADDR_W-1:2], 2'b00};
                s1_next.fwd  = write_data;
            end
        endcase
        if (!mode)
        begin
            s1_next.fwd = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

[rtl/tcmrd_match.sv]
`default_nettype none

module tcmrd_match (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcmrd_pkg::cfg_t cfg,
    input  wire tcmrd_pkg::s1_t  s1,
    output tcmrd_pkg::s2_t       s2
);

    tcmrd_pkg::s2_t s2_reg;
    tcmrd_pkg::s2_t s2_next;

    logic [1:0]                   perm;
    logic                         tcm_bus;
    logic [tcmrd_pkg::ADDR_W-1:0] itcm_diff;
    logic [tcmrd_pkg::ADDR_W-1:0] dtcm_diff;
    logic [3:0]                   vram_sel;
    logic                         drop;

    always_comb
    begin
        perm      = s1.wr ? 2'b10 : 2'b01;
        tcm_bus   = (s1.bus == tcmrd_pkg::BUS_CODE) || (s1.bus == tcmrd_pkg::BUS_DATA);
        itcm_diff = s1.addr - cfg.itcm_base;
        dtcm_diff = s1.addr - cfg.dtcm_base;
        vram_sel  = s1.addr[23:20];

        s2_next.valid    = s1.valid;
        s2_next.fwd      = s1.fwd;
        s2_next.itcm_hit = tcm_bus && ((cfg.itcm_access & perm) != 2'b00)
                           && (s1.addr >= cfg.itcm_base) && (s1.addr <= cfg.itcm_high);
        s2_next.dtcm_hit = (s1.bus == tcmrd_pkg::BUS_DATA)
                           && ((cfg.dtcm_access & perm) != 2'b00)
                           && (s1.addr >= cfg.dtcm_base) && (s1.addr <= cfg.dtcm_high);
        s2_next.itcm_off = itcm_diff[tcmrd_pkg::ITCM_OFF_W-1:0];
        s2_next.dtcm_off = dtcm_diff[tcmrd_pkg::DTCM_OFF_W-1:0];

        s2_next.region_tgt = tcmrd_pkg::TGT_UNMAPPED;
        s2_next.region_off = s1.addr;
        unique case (s1.addr[31:24])
            tcmrd_pkg::REGION_MAIN:
            begin
                s2_next.region_tgt = tcmrd_pkg::TGT_MAIN;
                s2_next.region_off = {{(tcmrd_pkg::ADDR_W-tcmrd_pkg::MAIN_OFF_W){1'b0}},
                                      s1.addr[tcmrd_pkg::MAIN_OFF_W-1:0]};
            end
            tcmrd_pkg::REGION_SHARED:
            begin
                if (cfg.shared_mapped)
                begin
                    s2_next.region_tgt = tcmrd_pkg::TGT_SHARED;
                end
                s2_next.region_off = s1.addr & cfg.shared_mask;
            end
            tcmrd_pkg::REGION_IO:      s2_next.region_tgt = tcmrd_pkg::TGT_IO;
            tcmrd_pkg::REGION_PALETTE: s2_next.region_tgt = tcmrd_pkg::TGT_PALETTE;
            tcmrd_pkg::REGION_VRAM:
            begin
                if (vram_sel[3])
                begin
                    s2_next.region_tgt = tcmrd_pkg::TGT_LCDC;
                end
                else
                begin
                    s2_next.region_tgt = tcmrd_pkg::tgt_t'(4'(tcmrd_pkg::TGT_VRAM_BG0)
                                                           + {2'b00, vram_sel[2:1]});
                end
            end
            tcmrd_pkg::REGION_OAM:     s2_next.region_tgt = tcmrd_pkg::TGT_OAM;
            tcmrd_pkg::REGION_BOOT:
            begin
                if (!s1.wr && (s1.addr[31:16] == tcmrd_pkg::BOOT_PAGE))
                begin
                    s2_next.region_tgt = tcmrd_pkg::TGT_BOOT;
                end
                s2_next.region_off = {{(tcmrd_pkg::ADDR_W-tcmrd_pkg::BOOT_OFF_W){1'b0}},
                                      s1.addr[tcmrd_pkg::BOOT_OFF_W-1:0]};
            end
            default:                   s2_next.region_tgt = tcmrd_pkg::TGT_UNMAPPED;
        endcase

        // byte stores to palette, vram and oam are discarded
        drop = s1.wr && s1.is_byte
               && ((s1.addr[31:24] == tcmrd_pkg::REGION_PALETTE)
                   || (s1.addr[31:24] == tcmrd_pkg::REGION_VRAM)
                   || (s1.addr[31:24] == tcmrd_pkg::REGION_OAM));
        if (drop)
        begin
            s2_next.region_tgt = tcmrd_pkg::TGT_DROP;
        end
        if (drop || (s2_next.region_tgt == tcmrd_pkg::TGT_UNMAPPED))
        begin
            s2_next.region_off = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

[rtl/tcmrd_select.sv]
`default_nettype none

module tcmrd_select (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tcmrd_pkg::s2_t               s2,
    output logic                              done,
    output logic [3:0]                        target,
    output logic [tcmrd_pkg::ADDR_W-1:0]      target_offset,
    output logic [tcmrd_pkg::DATA_W-1:0]      forward_data
);

    logic                         done_reg;
    tcmrd_pkg::tgt_t              tgt_reg;
    tcmrd_pkg::tgt_t              tgt_next;
    logic [tcmrd_pkg::ADDR_W-1:0] off_reg;
    logic [tcmrd_pkg::ADDR_W-1:0] off_next;
    logic [tcmrd_pkg::DATA_W-1:0] fwd_reg;
    logic [tcmrd_pkg::DATA_W-1:0] fwd_next;

    always_comb
    begin
        priority if (s2.itcm_hit)
        begin
            tgt_next = tcmrd_pkg::TGT_ITCM;
            off_next = {{(tcmrd_pkg::ADDR_W-tcmrd_pkg::ITCM_OFF_W){1'b0}}, s2.itcm_off};
        end
        else if (s2.dtcm_hit)
        begin
            tgt_next = tcmrd_pkg::TGT_DTCM;
            off_next = {{(tcmrd_pkg::ADDR_W-tcmrd_pkg::DTCM_OFF_W){1'b0}}, s2.dtcm_off};
        end
        else
        begin
            tgt_next = s2.region_tgt;
            off_next = s2.region_off;
        end
        fwd_next = s2.fwd;
        if ((tgt_next == tcmrd_pkg::TGT_UNMAPPED) || (tgt_next == tcmrd_pkg::TGT_DROP))
        begin
            fwd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            tgt_reg  <= tcmrd_pkg::TGT_UNMAPPED;
            off_reg  <= '0;
            fwd_reg  <= '0;
        end
        else
        begin
            done_reg <= s2.valid;
            tgt_reg  <= tgt_next;
            off_reg  <= off_next;
            fwd_reg  <= fwd_next;
        end
    end

    assign done          = done_reg;
    assign target        = tgt_reg;
    assign target_offset = off_reg;
    assign forward_data  = fwd_reg;

endmodule

`default_nettype wire

[rtl/tcm_and_region_address_decoder.sv]
// The result passes the align, match and select registers in turn before done carries it.
// Throughput: one access per cycle; busy is held low, the three stages
// (align, window/region compare, select) never stall as the receiver cannot.
// Reset: rst_n clears all registers and the stage valid bits; no clearing pass.
`default_nettype none

module tcm_and_region_address_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            mode,
    input  wire logic [tcmrd_pkg::ADDR_W-1:0]    access_addr,
    input  wire logic [1:0]                      access_size,
    input  wire logic [1:0]                      bus_kind,
    input  wire logic [tcmrd_pkg::DATA_W-1:0]    write_data,
    output logic                                 done,
    output logic [3:0]                           target,
    output logic [tcmrd_pkg::ADDR_W-1:0]         target_offset,
    output logic [tcmrd_pkg::DATA_W-1:0]         forward_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tcmrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcmrd_pkg::DATA_W-1:0]    cfg_data
);

    tcmrd_pkg::cfg_t cfg;
    tcmrd_pkg::s1_t  s1;
    tcmrd_pkg::s2_t  s2;

    assign busy = 1'b0;

    tcmrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcmrd_align u_align (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .mode        (mode),
        .access_addr (access_addr),
        .access_size (access_size),
        .bus_kind    (bus_kind),
        .write_data  (write_data),
        .s1          (s1)
    );

    tcmrd_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .s1    (s1),
        .s2    (s2)
    );

    tcmrd_select u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .s2            (s2),
        .done          (done),
        .target        (target),
        .target_offset (target_offset),
        .forward_data  (forward_data)
    );

`ifndef ASSERT_OFF
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("transfer accepted without result three cycles later");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without an accepted transfer");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((target == 4'(tcmrd_pkg::TGT_UNMAPPED))
                  || (target == 4'(tcmrd_pkg::TGT_DROP))))
        |-> ((target_offset == '0) && (forward_data == '0)))
        else $error("unmapped or dropped transfer carries offset or data");

    a_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |-> ##3 (forward_data == '0))
        else $error("read forwards non-zero data");
`endif

endmodule

`default_nettype wire

[sim/decode_checker.sv]
`default_nettype none

module decode_checker
    import tcmrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 mode,
    input  wire logic [ADDR_W-1:0]    access_addr,
    input  wire logic [1:0]           access_size,
    input  wire logic [1:0]           bus_kind,
    input  wire logic [DATA_W-1:0]    write_data,
    input  wire logic                 done,
    input  wire logic [3:0]           target,
    input  wire logic [ADDR_W-1:0]    target_offset,
    input  wire logic [DATA_W-1:0]    forward_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    output int                        outstanding,
    output int                        mismatches,
    output int                        compared
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] ITCM_MASK = (ADDR_W'(1) << ITCM_OFF_W) - 1;
    localparam logic [ADDR_W-1:0] DTCM_MASK = (ADDR_W'(1) << DTCM_OFF_W) - 1;
    localparam logic [ADDR_W-1:0] MAIN_MASK = (ADDR_W'(1) << MAIN_OFF_W) - 1;
    localparam logic [ADDR_W-1:0] BOOT_MASK = (ADDR_W'(1) << BOOT_OFF_W) - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        size_t             size;
        bus_t              bus;
        logic [DATA_W-1:0] wdata;
    } access_t;

    typedef struct {
        tgt_t              tgt;
        logic [ADDR_W-1:0] offset;
        logic [DATA_W-1:0] data;
    } decode_result_t;

    cfg_t           window_regs;
    decode_result_t decode_expect[$];
    int             error_count = 0;
    int             result_count = 0;

    initial begin
        outstanding = 0;
        mismatches  = 0;
        compared    = 0;
    end

    function automatic decode_result_t decode_access(input access_t acc, input cfg_t regs);
        decode_result_t    res;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        perm;
        logic [3:0]        sel;
        res.tgt    = TGT_UNMAPPED;
        res.offset = '0;
        addr       = acc.addr;
        case (acc.size)
            SIZE_BYTE: res.data = {24'b0, acc.wdata[7:0]};
            SIZE_HALF:
            begin
                addr[0]  = 1'b0;
                res.data = {16'b0, acc.wdata[15:0]};
            end
            default:
            begin
                addr[1:0] = 2'b00;
                res.data  = acc.wdata;
            end
        endcase
        if (!acc.wr)
            res.data = '0;
        perm = acc.wr ? 2'b10 : 2'b01;

        if ((acc.bus == BUS_CODE || acc.bus == BUS_DATA) && (regs.itcm_access & perm) != 2'b00
            && addr >= regs.itcm_base && addr <= regs.itcm_high)
        begin
            res.tgt    = TGT_ITCM;
            res.offset = (addr - regs.itcm_base) & ITCM_MASK;
        end
        else if (acc.bus == BUS_DATA && (regs.dtcm_access & perm) != 2'b00
                 && addr >= regs.dtcm_base && addr <= regs.dtcm_high)
        begin
            res.tgt    = TGT_DTCM;
            res.offset = (addr - regs.dtcm_base) & DTCM_MASK;
        end
        else
        begin
            case (addr[31:24])
                REGION_MAIN:
                begin
                    res.tgt    = TGT_MAIN;
                    res.offset = addr & MAIN_MASK;
                end
                REGION_SHARED:
                    if (regs.shared_mapped)
                    begin
                        res.tgt    = TGT_SHARED;
                        res.offset = addr & regs.shared_mask;
                    end
                REGION_IO:
                begin
                    res.tgt    = TGT_IO;
                    res.offset = addr;
                end
                REGION_PALETTE:
                begin
                    res.tgt    = TGT_PALETTE;
                    res.offset = addr;
                end
                REGION_VRAM:
                begin
                    sel        = addr[23:20];
                    res.tgt    = sel[3] ? TGT_LCDC : tgt_t'(4'(TGT_VRAM_BG0) + 4'(sel[2:1]));
                    res.offset = addr;
                end
                REGION_OAM:
                begin
                    res.tgt    = TGT_OAM;
                    res.offset = addr;
                end
                REGION_BOOT:
                    if (!acc.wr && addr[31:16] == BOOT_PAGE)
                    begin
                        res.tgt    = TGT_BOOT;
                        res.offset = addr & BOOT_MASK;
                    end
                default: ;
            endcase
            // byte stores cannot reach the video memories
            if (acc.wr && acc.size == SIZE_BYTE && (res.tgt == TGT_PALETTE || res.tgt == TGT_OAM
                || (res.tgt >= TGT_VRAM_BG0 && res.tgt <= TGT_LCDC)))
            begin
                res.tgt    = TGT_DROP;
                res.offset = '0;
                res.data   = '0;
            end
        end

        if (res.tgt == TGT_UNMAPPED)
        begin
            res.offset = '0;
            res.data   = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        access_t        acc;
        decode_result_t want;
        if (!rst_n)
        begin
            window_regs = '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ITCM_BASE:     window_regs.itcm_base     = cfg_data;
                    CFG_ITCM_HIGH:     window_regs.itcm_high     = cfg_data;
                    CFG_ITCM_ACCESS:   window_regs.itcm_access   = cfg_data[1:0];
                    CFG_DTCM_BASE:     window_regs.dtcm_base     = cfg_data;
                    CFG_DTCM_HIGH:     window_regs.dtcm_high     = cfg_data;
                    CFG_DTCM_ACCESS:   window_regs.dtcm_access   = cfg_data[1:0];
                    CFG_SHARED_MASK:   window_regs.shared_mask   = cfg_data;
                    CFG_SHARED_MAPPED: window_regs.shared_mapped = cfg_data[0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                acc.wr    = mode;
                acc.addr  = access_addr;
                acc.size  = size_t'(access_size);
                acc.bus   = bus_t'(bus_kind);
                acc.wdata = write_data;
                decode_expect.push_back(decode_access(acc, window_regs));
            end

            if (done)
            begin
                if (decode_expect.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result with nothing outstanding: target %0d off %h data %h",
                                 $realtime, target, target_offset, forward_data);
                end
                else
                begin
                    want = decode_expect.pop_front();
                    result_count++;
                    if (target !== want.tgt || target_offset !== want.offset
                        || forward_data !== want.data)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: decode mismatch: want %0d/%h/%h got %0d/%h/%h",
                                     $realtime, want.tgt, want.offset, want.data,
                                     target, target_offset, forward_data);
                    end
                end
            end

            outstanding <= decode_expect.size();
            mismatches  <= error_count;
            compared    <= result_count;
        end
    end

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tcmrd_pkg::*;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT   = 100000;
    localparam int   PHASE_ITEMS   = 140;
    localparam int   RANDOM_PHASES = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              mode = ACC_READ;
    logic [ADDR_W-1:0] access_addr = '0;
    logic [1:0]        access_size = SIZE_BYTE;
    logic [1:0]        bus_kind = BUS_CODE;
    logic [DATA_W-1:0] write_data = '0;
    logic              done;
    logic [3:0]        target;
    logic [ADDR_W-1:0] target_offset;
    logic [DATA_W-1:0] forward_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ITCM_BASE;
    logic [DATA_W-1:0]    cfg_data = '0;

    int   outstanding;
    int   mismatches;
    int   compared;
    int   cycle_count = 0;
    int   transfers_sent = 0;
    int   settings_applied = 0;
    int   burst_left = 0;
    cfg_t setting = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tcm_and_region_address_decoder DUT (
        .clk, .rst_n, .start, .busy, .mode, .access_addr, .access_size, .bus_kind,
        .write_data, .done, .target, .target_offset, .forward_data,
        .cfg_wr_en, .cfg_index, .cfg_data
    );

    decode_checker checker_i (
        .clk, .rst_n, .start, .busy, .mode, .access_addr, .access_size, .bus_kind,
        .write_data, .done, .target, .target_offset, .forward_data,
        .cfg_wr_en, .cfg_index, .cfg_data, .outstanding, .mismatches, .compared
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic drive_access(input logic wr, input logic [ADDR_W-1:0] addr,
                                input logic [1:0] size, input logic [1:0] bus,
                                input logic [DATA_W-1:0] data);
        int gap;
        start       <= 1'b1;
        mode        <= wr;
        access_addr <= addr;
        access_size <= size;
        bus_kind    <= bus;
        write_data  <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        transfers_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t s);
        logic [DATA_W-1:0] value;
        setting = s;
        for (int i = 0; i < 8; i++)
        begin
            case (cfg_idx_t'(i))
                CFG_ITCM_BASE:     value = s.itcm_base;
                CFG_ITCM_HIGH:     value = s.itcm_high;
                CFG_ITCM_ACCESS:   value = 32'(s.itcm_access);
                CFG_DTCM_BASE:     value = s.dtcm_base;
                CFG_DTCM_HIGH:     value = s.dtcm_high;
                CFG_DTCM_ACCESS:   value = 32'(s.dtcm_access);
                CFG_SHARED_MASK:   value = s.shared_mask;
                default:           value = 32'(s.shared_mapped);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= value;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    function automatic logic [ADDR_W-1:0] window_base();
        logic [ADDR_W-1:0] b;
        b = $urandom();
        if ($urandom_range(0, 2) != 0)
            b[31:24] = 8'($urandom_range(0, 7));
        return b;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t s;
        s.itcm_base     = window_base();
        s.itcm_high     = s.itcm_base + (($urandom_range(0, 4) == 0) ? $urandom()
                                         : $urandom_range(0, 32'h0002_0000));
        s.itcm_access   = 2'($urandom_range(0, 3));
        s.dtcm_base     = window_base();
        s.dtcm_high     = s.dtcm_base + (($urandom_range(0, 4) == 0) ? $urandom()
                                         : $urandom_range(0, 32'h0001_0000));
        s.dtcm_access   = 2'($urandom_range(0, 3));
        s.shared_mask   = ($urandom_range(0, 1) == 0) ? $urandom() : (32'hFFFF_FFFF >> $urandom_range(0, 31));
        s.shared_mapped = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        a = $urandom();
        case ($urandom_range(0, 13))
            0:  a = setting.itcm_base + 32'($urandom_range(0, 16)) - 32'd8;
            1:  a = setting.itcm_high + 32'($urandom_range(0, 16)) - 32'd8;
            2:  a = setting.dtcm_base + 32'($urandom_range(0, 16)) - 32'd8;
            3:  a = setting.dtcm_high + 32'($urandom_range(0, 16)) - 32'd8;
            4:  a[31:16] = BOOT_PAGE;
            5:  a[31:24] = REGION_BOOT;
            6:  a[31:24] = REGION_MAIN;
            7:  a[31:24] = REGION_SHARED;
            8:  a[31:24] = REGION_IO;
            9:  a[31:24] = REGION_PALETTE;
            10: a[31:24] = REGION_VRAM;
            11: a[31:24] = REGION_OAM;
            12: a[31:24] = 8'($urandom_range(0, 8));
            default: ;
        endcase
        return a;
    endfunction

    task automatic random_accesses(input int count);
        for (int i = 0; i < count; i++)
            drive_access(1'($urandom_range(0, 1)), pick_address(), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), $urandom());
    endtask

    task automatic directed_accesses;
        drive_access(ACC_READ,  32'h0000_1233, SIZE_WORD, BUS_CODE,   32'hFFFF_FFFF);
        drive_access(ACC_WRITE, 32'h0000_0100, SIZE_WORD, BUS_CODE,   32'hFFFF_FFFF);
        drive_access(ACC_READ,  32'h0000_0000, SIZE_BYTE, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_READ,  32'h0000_0010, SIZE_WORD, BUS_SYSTEM, 32'h1234_5678);
        drive_access(ACC_READ,  32'h0000_0010, SIZE_WIDE, BUS_OTHER,  32'h1234_5678);
        drive_access(ACC_READ,  32'h0080_3FFF, SIZE_HALF, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'h0080_0001, SIZE_BYTE, BUS_DATA,   32'hFFFF_FFFF);
        drive_access(ACC_READ,  32'h0080_0004, SIZE_WORD, BUS_CODE,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'h02FF_FFFF, SIZE_WORD, BUS_DATA,   32'hDEAD_BEEF);
        drive_access(ACC_READ,  32'h0312_3456, SIZE_HALF, BUS_SYSTEM, 32'h0000_0000);
        drive_access(ACC_WRITE, 32'h0400_0131, SIZE_HALF, BUS_DATA,   32'hA5A5_5A5A);
        drive_access(ACC_WRITE, 32'h0500_0001, SIZE_BYTE, BUS_DATA,   32'hFFFF_FFFF);
        drive_access(ACC_WRITE, 32'h0500_0003, SIZE_HALF, BUS_DATA,   32'hFFFF_FFFF);
        drive_access(ACC_READ,  32'h0610_0000, SIZE_WORD, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_READ,  32'h0620_0000, SIZE_WORD, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_READ,  32'h0650_0000, SIZE_WORD, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'h0670_0002, SIZE_WIDE, BUS_DATA,   32'h0F0F_F0F0);
        drive_access(ACC_READ,  32'h06F0_0000, SIZE_WORD, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'h0680_0000, SIZE_BYTE, BUS_DATA,   32'h0000_00FF);
        drive_access(ACC_READ,  32'h07FF_FFFF, SIZE_WORD, BUS_DATA,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'h0700_0000, SIZE_BYTE, BUS_DATA,   32'h0000_0011);
        drive_access(ACC_READ,  32'hFFFF_FFFF, SIZE_WIDE, BUS_CODE,   32'h0000_0000);
        drive_access(ACC_READ,  32'hFFFE_FFFF, SIZE_WORD, BUS_CODE,   32'h0000_0000);
        drive_access(ACC_WRITE, 32'hFFFF_0000, SIZE_WORD, BUS_DATA,   32'hFFFF_FFFF);
        drive_access(ACC_WRITE, 32'h0800_0000, SIZE_WORD, BUS_DATA,   32'hFFFF_FFFF);
    endtask

    initial
    begin
        cfg_t s;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first: empty windows, shared RAM unmapped
        random_accesses(PHASE_ITEMS);
        drain();

        s = '{itcm_base: 32'h0000_0000, itcm_high: 32'h0000_7FFF, itcm_access: 2'b01,
              dtcm_base: 32'h0080_0000, dtcm_high: 32'h0080_3FFF, dtcm_access: 2'b11,
              shared_mask: 32'h0000_7FFF, shared_mapped: 1'b1};
        apply_setting(s);
        directed_accesses();
        random_accesses(PHASE_ITEMS - 25);
        drain();

        s = '{itcm_base: 32'h0000_0000, itcm_high: 32'hFFFF_FFFF, itcm_access: 2'b11,
              dtcm_base: 32'h0000_0000, dtcm_high: 32'hFFFF_FFFF, dtcm_access: 2'b11,
              shared_mask: 32'hFFFF_FFFF, shared_mapped: 1'b1};
        apply_setting(s);
        random_accesses(PHASE_ITEMS);
        drain();

        s = '{itcm_base: 32'hFFFF_FFFF, itcm_high: 32'h0000_0000, itcm_access: 2'b10,
              dtcm_base: 32'hFFFF_FFFC, dtcm_high: 32'hFFFF_FFFF, dtcm_access: 2'b01,
              shared_mask: 32'h0000_0000, shared_mapped: 1'b1};
        apply_setting(s);
        random_accesses(PHASE_ITEMS);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_setting(random_setting());
            random_accesses(PHASE_ITEMS);
            drain();
        end

        $display("summary: %0d accesses under %0d register settings, %0d decodes compared",
                 transfers_sent, settings_applied + 1, compared);
        $display("summary: directed region, window and drop cases plus random bursts");
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/tcmrd_pkg.sv
rtl/tcmrd_cfg.sv
rtl/tcmrd_align.sv
rtl/tcmrd_match.sv
rtl/tcmrd_select.sv
rtl/tcm_and_region_address_decoder.sv
sim/decode_checker.sv
sim/testbench.sv
